// ===== rtl/fshp_pkg.sv =====
// Shared constants, types and helpers for the fan speed hysteresis policy block.
package fshp_pkg;

  localparam int unsigned TempW    = 19;
  localparam int unsigned PctW     = 7;
  localparam int unsigned LevelsW  = 4 * PctW;
  localparam int unsigned FanW     = 5;
  localparam int unsigned FanCount = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = LevelsW;

  localparam logic [FanW-1:0] FanMask = FanW'((1 << FanCount) - 1);

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [PctW-1:0]         pct_t;
  typedef logic [LevelsW-1:0]      levels_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;
  typedef logic [1:0]              slot_t;

  localparam cfg_idx_t RegUpFull   = 3'd0;
  localparam cfg_idx_t RegUpHigh   = 3'd1;
  localparam cfg_idx_t RegUpMid    = 3'd2;
  localparam cfg_idx_t RegDownHigh = 3'd3;
  localparam cfg_idx_t RegDownMid  = 3'd4;
  localparam cfg_idx_t RegDownLow  = 3'd5;
  localparam cfg_idx_t RegLevels   = 3'd6;

  localparam slot_t SlotFull = 2'd0;
  localparam slot_t SlotHigh = 2'd1;
  localparam slot_t SlotMid  = 2'd2;
  localparam slot_t SlotLow  = 2'd3;

  localparam temp_t   RstUpFull   = 19'sd57500;
  localparam temp_t   RstUpHigh   = 19'sd53000;
  localparam temp_t   RstUpMid    = 19'sd49500;
  localparam temp_t   RstDownHigh = 19'sd52700;
  localparam temp_t   RstDownMid  = 19'sd47700;
  localparam temp_t   RstDownLow  = 19'sd42700;
  localparam levels_t RstLevels   = 28'd84961380;

  function automatic pct_t level_pct(levels_t levels, slot_t slot);
    pct_t pct;
    case (slot)
      SlotFull: pct = levels[PctW-1:0];
      SlotHigh: pct = levels[2*PctW-1:PctW];
      SlotMid:  pct = levels[3*PctW-1:2*PctW];
      SlotLow:  pct = levels[4*PctW-1:3*PctW];
      default:  pct = levels[PctW-1:0];
    endcase
    return pct;
  endfunction

endpackage

// ===== rtl/fan_speed_hysteresis_policy.sv =====
// Top level of the stepped fan speed policy with temperature hysteresis.
//
// Input channel: in_valid_i / in_stall_o carry two temperature readings in
// millidegrees and a mask of failed fans. Output channel: out_valid_o /
// out_stall_i carry a new fan duty percentage, emitted only when the
// selected level differs from the last committed one.
// A transaction is registered on acceptance into the evaluation stage, evaluated
// against the committed temperature and speed, and its result, if any, is
// registered into the output register as the stage advances. One transaction
// per cycle is sustained while out_stall_i is low; the single evaluation stage
// sets that figure, since the committed state is updated as the stage advances.
// When the receiver stalls with a result pending, the evaluation stage holds and
// in_stall_o rises once that stage is also occupied. Configuration writes
// (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the next edge; the user
// makes them only while idle (the block does not enforce it); unknown indexes drop.
// Reset restores the default thresholds and levels, clears the committed
// temperature and speed, and empties both stages.
module fan_speed_hysteresis_policy (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fshp_pkg::TempW-1:0] temp_a_i,
  input  logic signed [fshp_pkg::TempW-1:0] temp_b_i,
  input  logic [fshp_pkg::FanW-1:0]         fan_failed_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fshp_pkg::PctW-1:0]         speed_percent_o,
  input  logic                              cfg_we_i,
  input  logic [fshp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fshp_pkg::CfgDataW-1:0]     cfg_data_i
);

  fshp_pkg::temp_t   up_full_q, up_high_q, up_mid_q;
  fshp_pkg::temp_t   down_high_q, down_mid_q, down_low_q;
  fshp_pkg::levels_t levels_q;

  fshp_pkg::temp_t   last_temp_q, last_temp_d;
  fshp_pkg::pct_t    last_speed_q, last_speed_d;

  logic                      s1_valid_q;
  fshp_pkg::temp_t           s1_temp_a_q, s1_temp_b_q;
  logic [fshp_pkg::FanW-1:0] s1_mask_q;

  logic           out_valid_q, out_valid_d;
  fshp_pkg::pct_t out_pct_q, out_pct_d;

  logic                      advance, in_accept;
  logic signed [fshp_pkg::TempW:0] sum, sum_adj;
  fshp_pkg::temp_t           avg;
  fshp_pkg::slot_t           slot;
  logic                      no_change;
  fshp_pkg::pct_t            pct;
  logic                      emit;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_full_q   <= fshp_pkg::RstUpFull;
      up_high_q   <= fshp_pkg::RstUpHigh;
      up_mid_q    <= fshp_pkg::RstUpMid;
      down_high_q <= fshp_pkg::RstDownHigh;
      down_mid_q  <= fshp_pkg::RstDownMid;
      down_low_q  <= fshp_pkg::RstDownLow;
      levels_q    <= fshp_pkg::RstLevels;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fshp_pkg::RegUpFull:   up_full_q   <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegUpHigh:   up_high_q   <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegUpMid:    up_mid_q    <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegDownHigh: down_high_q <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegDownMid:  down_mid_q  <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegDownLow:  down_low_q  <= cfg_data_i[fshp_pkg::TempW-1:0];
        fshp_pkg::RegLevels:   levels_q    <= cfg_data_i[fshp_pkg::LevelsW-1:0];
        default: ;
      endcase
    end
  end

  // Average, truncating toward zero
  always_comb begin
    sum     = {s1_temp_a_q[fshp_pkg::TempW-1], s1_temp_a_q}
            + {s1_temp_b_q[fshp_pkg::TempW-1], s1_temp_b_q};
    sum_adj = sum + {{fshp_pkg::TempW{1'b0}}, sum[fshp_pkg::TempW] & sum[0]};
    avg     = sum_adj[fshp_pkg::TempW:1];
  end

  always_comb begin
    no_change = 1'b0;
    if ((s1_mask_q & fshp_pkg::FanMask) != '0) begin
      slot = fshp_pkg::SlotFull;
    end else if (avg == last_temp_q) begin
      slot      = fshp_pkg::SlotFull;
      no_change = 1'b1;
    end else if (avg > last_temp_q) begin
      if (avg >= up_full_q) slot = fshp_pkg::SlotFull;
      else if (avg >= up_high_q) slot = fshp_pkg::SlotHigh;
      else if (avg >= up_mid_q) slot = fshp_pkg::SlotMid;
      else slot = fshp_pkg::SlotLow;
    end else begin
      if (avg <= down_low_q) slot = fshp_pkg::SlotLow;
      else if (avg <= down_mid_q) slot = fshp_pkg::SlotMid;
      else if (avg <= down_high_q) slot = fshp_pkg::SlotHigh;
      else slot = fshp_pkg::SlotFull;
    end
    pct  = fshp_pkg::level_pct(levels_q, slot);
    emit = s1_valid_q && !no_change && (pct != last_speed_q);
  end

  always_comb begin
    last_temp_d  = last_temp_q;
    last_speed_d = last_speed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_pct_d    = out_pct_q;
    if (advance && emit) begin
      last_temp_d  = avg;
      last_speed_d = pct;
      out_valid_d  = 1'b1;
      out_pct_d    = pct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_temp_q  <= '0;
      last_speed_q <= '0;
    end else begin
      if (advance || in_accept) s1_valid_q <= in_accept;
      out_valid_q  <= out_valid_d;
      last_temp_q  <= last_temp_d;
      last_speed_q <= last_speed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_temp_a_q <= temp_a_i;
      s1_temp_b_q <= temp_b_i;
      s1_mask_q   <= fan_failed_mask_i;
    end
    out_pct_q <= out_pct_d;
  end

  assign out_valid_o     = out_valid_q;
  assign speed_percent_o = out_pct_q;

endmodule
